// File: rtl/mfep_pkg.sv
package mfep_pkg;

  localparam int MaxVarintBytes = 4;
  localparam int TimeBits       = 32;

  localparam logic [31:0] TagHead  = 32'h4D546864;
  localparam logic [31:0] TagTrack = 32'h4D54726B;

  typedef enum logic [4:0] {
    P_HTAG, P_HLEN, P_HFMT, P_HNTRK, P_HDIV, P_CTAG, P_CLEN_TRK, P_CLEN_SKIP,
    P_SKIP, P_DELTA, P_STATUS, P_DATA, P_SYXLEN, P_SYXDATA, P_MTYPE, P_MLEN,
    P_MDATA, P_DONE, P_ERR
  } phase_e;

  typedef enum logic [4:0] {
    E_TRUNC, E_HTAG, E_HLEN, E_HFMT, E_HNTRK, E_HDIV, E_SKIPSZ, E_TRKSZ,
    E_AFTER_EOT, E_DELTA_LONG, E_NO_RUN, E_BAD_STATUS, E_SYX_LONG, E_SYX_EMPTY,
    E_SYX_END, E_META_LONG, E_META_LEN, E_CHAN_RANGE, E_CHAN_MISMATCH,
    E_DATA_HIGH, E_OVERRUN, E_NO_EOT
  } err_e;

  typedef enum logic [1:0] {
    K_EVENT = 2'd0, K_TRACK = 2'd1, K_FILE = 2'd2, K_ERROR = 2'd3
  } kind_e;

  localparam logic [7:0] MetaChan  = 8'h20;
  localparam logic [7:0] MetaEot   = 8'h2F;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [7:0] MetaSmpte = 8'h54;
  localparam logic [7:0] MetaTsig  = 8'h58;

  // One result word: kind, track, time, status, three args, channel, error, division, last flag.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] trk;
    logic [31:0] tim;
    logic [7:0]  st;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [7:0]  a3;
    logic [4:0]  chan;
    logic [4:0]  err;
    logic [14:0] tpq;
    logic        last;
  } res_t;

  localparam int ResBits = $bits(res_t);

endpackage

// File: rtl/mfep_core.sv
// Byte parser: all state updates for one byte are made together; up to two results.
module mfep_core #(
  parameter int MaxVarintBytes = mfep_pkg::MaxVarintBytes,
  parameter int TimeBits       = mfep_pkg::TimeBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             eof_i,
  output logic [1:0]       n_o,
  output mfep_pkg::res_t   r0_o,
  output mfep_pkg::res_t   r1_o
);

  localparam logic [31:0] TimeMask = 32'((64'd1 << TimeBits) - 64'd1);

  mfep_pkg::phase_e ph_q, ph_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [31:0] fsh_q, fsh_d;
  logic [15:0] tdecl_q, tdecl_d, tdone_q, tdone_d;
  logic [31:0] cleft_q, cleft_d;
  logic [27:0] dacc_q, dacc_d;
  logic [2:0]  vlen_q, vlen_d;
  logic [31:0] clk_q, clk_d;
  logic [7:0]  run_q, run_d;
  logic [4:0]  chan_q, chan_d;
  logic        eot_q, eot_d;
  logic [7:0]  mk_q, mk_d;
  logic [27:0] pl_q, pl_d;
  logic [7:0]  eb_q [3];
  logic [7:0]  eb_d [3];
  logic [31:0] send_q, send_d;
  logic [14:0] div_q, div_d;
  logic        errl_q, errl_d;

  // Combinational scratch for the single byte step.
  mfep_pkg::res_t rr [2];
  logic [1:0]  n;
  logic        vdone, vlong;
  logic [27:0] vacc;
  logic [31:0] v;
  logic [2:0]  need;
  logic [3:0]  h;
  logic [1:0]  dneed;
  logic        emit, chunk_end, data_path, meta_path, st_ok;
  logic [7:0]  st, c;
  logic [7:0]  b;
  logic [2:0]  mlen;
  logic [15:0] tnext;
  mfep_pkg::err_e ecode;
  logic        efire;

  always_comb begin
    ph_d = ph_q; fbc_d = fbc_q; fsh_d = fsh_q; tdecl_d = tdecl_q; tdone_d = tdone_q;
    cleft_d = cleft_q; dacc_d = dacc_q; vlen_d = vlen_q; clk_d = clk_q; run_d = run_q;
    chan_d = chan_q; eot_d = eot_q; mk_d = mk_q; pl_d = pl_q; eb_d = eb_q;
    send_d = send_q; div_d = div_q; errl_d = errl_q;
    rr[0] = '0; rr[1] = '0; n = 2'd0;
    efire = 1'b0; ecode = mfep_pkg::E_TRUNC;
    b = byte_i;
    vdone = 1'b0; vlong = 1'b0; vacc = '0; v = '0; need = 3'd4; h = '0; dneed = 2'd2;
    emit = 1'b0; chunk_end = 1'b0; data_path = 1'b0; meta_path = 1'b0; st_ok = 1'b0;
    st = '0; c = '0; mlen = '0; tnext = tdone_q + 16'd1;

    // Shared varuint step on either the delta or the payload accumulator.
    vacc = ((ph_q == mfep_pkg::P_DELTA) ? dacc_q : pl_q);
    vacc = {vacc[20:0], b[6:0]};
    if (!b[7]) vdone = 1'b1;
    else if (32'(vlen_q) + 32'd1 >= 32'(MaxVarintBytes)) vlong = 1'b1;

    if (step_i && !errl_q && ph_q != mfep_pkg::P_DONE && ph_q != mfep_pkg::P_ERR) begin
      if (ph_q <= mfep_pkg::P_CLEN_SKIP) begin
        // Header and chunk framing fields, big-endian.
        v = {fsh_q[23:0], b};
        need = (ph_q == mfep_pkg::P_HFMT || ph_q == mfep_pkg::P_HNTRK ||
                ph_q == mfep_pkg::P_HDIV) ? 3'd2 : 3'd4;
        fsh_d = v;
        fbc_d = fbc_q + 3'd1;
        if (fbc_q + 3'd1 >= need) begin
          fbc_d = '0; fsh_d = '0;
          unique case (ph_q)
            mfep_pkg::P_HTAG: if (v != mfep_pkg::TagHead) begin
              efire = 1'b1; ecode = mfep_pkg::E_HTAG;
            end else ph_d = mfep_pkg::P_HLEN;
            mfep_pkg::P_HLEN: if (v != 32'd6) begin
              efire = 1'b1; ecode = mfep_pkg::E_HLEN;
            end else ph_d = mfep_pkg::P_HFMT;
            mfep_pkg::P_HFMT: if (v != 32'd1) begin
              efire = 1'b1; ecode = mfep_pkg::E_HFMT;
            end else ph_d = mfep_pkg::P_HNTRK;
            mfep_pkg::P_HNTRK: if (v[15:0] == 16'd0) begin
              efire = 1'b1; ecode = mfep_pkg::E_HNTRK;
            end else begin
              tdecl_d = v[15:0]; ph_d = mfep_pkg::P_HDIV;
            end
            mfep_pkg::P_HDIV: if (v[15]) begin
              efire = 1'b1; ecode = mfep_pkg::E_HDIV;
            end else begin
              div_d = v[14:0]; ph_d = mfep_pkg::P_CTAG;
            end
            mfep_pkg::P_CTAG:
              ph_d = (v == mfep_pkg::TagTrack) ? mfep_pkg::P_CLEN_TRK
                                                : mfep_pkg::P_CLEN_SKIP;
            mfep_pkg::P_CLEN_TRK: if (v[31]) begin
              efire = 1'b1; ecode = mfep_pkg::E_TRKSZ;
            end else if (v == 32'd0) begin
              efire = 1'b1; ecode = mfep_pkg::E_NO_EOT;
            end else begin
              cleft_d = v; clk_d = '0; run_d = '0; chan_d = 5'd16; eot_d = 1'b0;
              dacc_d = '0; vlen_d = '0; pl_d = '0; ph_d = mfep_pkg::P_DELTA;
            end
            default: if (v[31]) begin
              efire = 1'b1; ecode = mfep_pkg::E_SKIPSZ;
            end else begin
              cleft_d = v;
              if (v == 32'd0) chunk_end = 1'b1;
              else ph_d = mfep_pkg::P_SKIP;
            end
          endcase
        end
      end else if (ph_q == mfep_pkg::P_SKIP) begin
        cleft_d = cleft_q - 32'd1;
        if (cleft_q == 32'd1) chunk_end = 1'b1;
      end else if (cleft_q == 32'd0) begin
        efire = 1'b1; ecode = mfep_pkg::E_OVERRUN;
      end else begin
        cleft_d = cleft_q - 32'd1;
        unique case (ph_q)
          mfep_pkg::P_DELTA: begin
            vlen_d = vlen_q + 3'd1;
            dacc_d = vacc;
            if (vlong) begin
              vlen_d = '0; efire = 1'b1; ecode = mfep_pkg::E_DELTA_LONG;
            end else if (vdone) begin
              vlen_d = '0;
              clk_d = (clk_q + 32'(vacc)) & TimeMask;
              dacc_d = '0; ph_d = mfep_pkg::P_STATUS;
            end
          end
          mfep_pkg::P_STATUS: begin
            st = b[7] ? b : run_q;
            if (!b[7] && !run_q[7]) begin
              efire = 1'b1; ecode = mfep_pkg::E_NO_RUN;
            end else if (st == 8'hF0) begin
              run_d = '0; pl_d = '0; ph_d = mfep_pkg::P_SYXLEN;
            end else if (st == 8'hFF) begin
              run_d = '0; ph_d = mfep_pkg::P_MTYPE;
            end else if (st[7:4] == 4'hF) begin
              efire = 1'b1; ecode = mfep_pkg::E_BAD_STATUS;
            end else if (chan_q != 5'd16 && chan_q != {1'b0, st[3:0]}) begin
              run_d = st; efire = 1'b1; ecode = mfep_pkg::E_CHAN_MISMATCH;
            end else begin
              run_d = st; chan_d = {1'b0, st[3:0]}; mk_d = st; fbc_d = '0;
              ph_d = mfep_pkg::P_DATA;
              if (!b[7]) data_path = 1'b1;
            end
          end
          mfep_pkg::P_DATA: data_path = 1'b1;
          mfep_pkg::P_SYXLEN, mfep_pkg::P_MLEN: begin
            vlen_d = vlen_q + 3'd1;
            pl_d = vacc;
            if (vlong) begin
              vlen_d = '0; efire = 1'b1;
              ecode = (ph_q == mfep_pkg::P_SYXLEN) ? mfep_pkg::E_SYX_LONG
                                                   : mfep_pkg::E_META_LONG;
            end else if (vdone) begin
              vlen_d = '0;
              if (ph_q == mfep_pkg::P_SYXLEN) begin
                if (vacc == '0) begin
                  efire = 1'b1; ecode = mfep_pkg::E_SYX_EMPTY;
                end else ph_d = mfep_pkg::P_SYXDATA;
              end else begin
                fbc_d = '0;
                if (vacc == '0) begin
                  meta_path = 1'b1; mlen = 3'd0;
                end else ph_d = mfep_pkg::P_MDATA;
              end
            end
          end
          mfep_pkg::P_SYXDATA: begin
            pl_d = pl_q - 28'd1;
            if (pl_q == 28'd1) begin
              if (b != 8'hF7) begin
                efire = 1'b1; ecode = mfep_pkg::E_SYX_END;
              end else begin
                ph_d = mfep_pkg::P_DELTA; data_path = 1'b0;
                meta_path = 1'b0;
                st_ok = 1'b1;
              end
            end
          end
          mfep_pkg::P_MTYPE: begin
            mk_d = b; pl_d = '0; ph_d = mfep_pkg::P_MLEN;
          end
          default: begin
            if (fbc_q < 3'd3) eb_d[fbc_q[1:0]] = b;
            mlen = (fbc_q < 3'd7) ? fbc_q + 3'd1 : fbc_q;
            fbc_d = mlen;
            pl_d = pl_q - 28'd1;
            if (pl_q == 28'd1) meta_path = 1'b1;
          end
        endcase

        // Channel message data byte.
        if (data_path) begin
          h = mk_d[7:4];
          dneed = (h == 4'hC || h == 4'hD) ? 2'd1 : 2'd2;
          if (b[7]) begin
            efire = 1'b1; ecode = mfep_pkg::E_DATA_HIGH;
          end else begin
            if (fbc_d < 3'd2) eb_d[fbc_d[1:0]] = b;
            fbc_d = fbc_d + 3'd1;
            if (fbc_d >= 3'(dneed)) begin
              c = eb_d[0];
              if (h == 4'hB)
                emit = c == 8'd1 || c == 8'd7 || c == 8'd10 || c == 8'd64 ||
                       c == 8'd91 || c == 8'd121;
              else
                emit = h == 4'h8 || h == 4'h9 || h == 4'hC || h == 4'hE;
              if (emit) begin
                rr[0] = '0; rr[0].kind = mfep_pkg::K_EVENT; rr[0].trk = tdone_q;
                rr[0].tim = clk_d; rr[0].st = mk_d; rr[0].a1 = eb_d[0];
                rr[0].a2 = (dneed == 2'd2) ? eb_d[1] : 8'd0;
                n = 2'd1;
              end
              st_ok = 1'b1;
            end
          end
        end

        // Meta completion.
        if (meta_path) begin
          st_ok = 1'b1;
          unique case (mk_d)
            mfep_pkg::MetaChan: if (mlen != 3'd1) begin
              efire = 1'b1; ecode = mfep_pkg::E_META_LEN; st_ok = 1'b0;
            end else if (chan_q == 5'd16) begin
              if (eb_d[0] > 8'd15) begin
                efire = 1'b1; ecode = mfep_pkg::E_CHAN_RANGE; st_ok = 1'b0;
              end else chan_d = eb_d[0][4:0];
            end
            mfep_pkg::MetaEot: if (mlen != 3'd0) begin
              efire = 1'b1; ecode = mfep_pkg::E_META_LEN; st_ok = 1'b0;
            end else begin
              eot_d = 1'b1;
              if (clk_q >= send_q) send_d = clk_q;
            end
            mfep_pkg::MetaTempo: if (mlen != 3'd3) begin
              efire = 1'b1; ecode = mfep_pkg::E_META_LEN; st_ok = 1'b0;
            end else begin
              rr[0] = '0; rr[0].kind = mfep_pkg::K_EVENT; rr[0].trk = tdone_q;
              rr[0].tim = clk_q; rr[0].st = mfep_pkg::MetaTempo;
              rr[0].a1 = eb_d[0]; rr[0].a2 = eb_d[1]; rr[0].a3 = eb_d[2];
              n = 2'd1;
            end
            mfep_pkg::MetaSmpte: if (mlen != 3'd5) begin
              efire = 1'b1; ecode = mfep_pkg::E_META_LEN; st_ok = 1'b0;
            end
            mfep_pkg::MetaTsig: if (mlen != 3'd4) begin
              efire = 1'b1; ecode = mfep_pkg::E_META_LEN; st_ok = 1'b0;
            end else begin
              rr[0] = '0; rr[0].kind = mfep_pkg::K_EVENT; rr[0].trk = tdone_q;
              rr[0].tim = clk_q; rr[0].st = mfep_pkg::MetaTsig;
              rr[0].a1 = eb_d[0]; rr[0].a2 = eb_d[1];
              n = 2'd1;
            end
            default: ;
          endcase
        end

        // End of an event: track end or a byte after the end marker.
        if (st_ok) begin
          ph_d = mfep_pkg::P_DELTA;
          if (cleft_d == 32'd0) begin
            if (!eot_d) begin
              efire = 1'b1; ecode = mfep_pkg::E_NO_EOT;
            end else begin
              rr[n[0]] = '0; rr[n[0]].kind = mfep_pkg::K_TRACK;
              rr[n[0]].trk = tdone_q; rr[n[0]].chan = chan_d;
              n = n + 2'd1;
              chunk_end = 1'b1;
            end
          end else if (eot_d) begin
            efire = 1'b1; ecode = mfep_pkg::E_AFTER_EOT;
          end
        end
      end

      // Chunk finished: count it, maybe close the file.
      if (chunk_end) begin
        tdone_d = tnext;
        if (tnext == tdecl_q) begin
          ph_d = mfep_pkg::P_DONE;
          rr[n[0]] = '0; rr[n[0]].kind = mfep_pkg::K_FILE; rr[n[0]].trk = tnext;
          rr[n[0]].tim = send_d; rr[n[0]].tpq = div_d;
          n = n + 2'd1;
        end else ph_d = mfep_pkg::P_CTAG;
      end

      if (!efire && eof_i && ph_d != mfep_pkg::P_DONE) begin
        efire = 1'b1; ecode = mfep_pkg::E_TRUNC;
      end
      if (efire) begin
        errl_d = 1'b1; ph_d = mfep_pkg::P_ERR;
        if (n < 2'd2) begin
          rr[n[0]] = '0; rr[n[0]].kind = mfep_pkg::K_ERROR; rr[n[0]].trk = tdone_d;
          rr[n[0]].err = ecode;
          n = n + 2'd1;
        end
      end
      if (n == 2'd1) rr[0].last = 1'b1;
      if (n == 2'd2) rr[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= mfep_pkg::P_HTAG; fbc_q <= '0; fsh_q <= '0; tdecl_q <= '0; tdone_q <= '0;
      cleft_q <= '0; dacc_q <= '0; vlen_q <= '0; clk_q <= '0; run_q <= '0;
      chan_q <= 5'd16; eot_q <= 1'b0; mk_q <= '0; pl_q <= '0;
      eb_q[0] <= '0; eb_q[1] <= '0; eb_q[2] <= '0;
      send_q <= '0; div_q <= '0; errl_q <= 1'b0;
    end else begin
      ph_q <= ph_d; fbc_q <= fbc_d; fsh_q <= fsh_d; tdecl_q <= tdecl_d; tdone_q <= tdone_d;
      cleft_q <= cleft_d; dacc_q <= dacc_d; vlen_q <= vlen_d; clk_q <= clk_d;
      run_q <= run_d; chan_q <= chan_d; eot_q <= eot_d; mk_q <= mk_d; pl_q <= pl_d;
      eb_q <= eb_d; send_q <= send_d; div_q <= div_d; errl_q <= errl_d;
    end
  end

  assign n_o  = n;
  assign r0_o = rr[0];
  assign r1_o = rr[1];

endmodule

// File: rtl/mfep_outq.sv
// Result queue: four words, takes up to two per cycle, gives one.
module mfep_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     n_i,
  input  mfep_pkg::res_t r0_i,
  input  mfep_pkg::res_t r1_i,
  output logic           space_o,
  output logic           valid_o,
  output mfep_pkg::res_t word_o,
  input  logic           take_i
);

  mfep_pkg::res_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && take_i;
  assign valid_o = cnt_q != 3'd0;
  assign word_o  = mem_q[rp_q];
  // Room for two more words even if nothing leaves this cycle.
  assign space_o = cnt_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (n_i != 2'd0) mem_q[wp_q] <= r0_i;
    if (n_i == 2'd2) mem_q[wp_q + 2'd1] <= r1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_i;
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n_i} - {2'b0, pop};
    end
  end

endmodule

// File: rtl/midi_file_event_parser.sv
// One file byte is taken per cycle while the result queue has room for two words.
// Results are registered in the result queue before they appear at the master side.
// Throughput: one byte per cycle while the queue has room; the second result of a
// byte is buffered in the four-word result queue.
// Reset (rst_ni low, asynchronous) returns the parser to await the header tag.
module midi_file_event_parser #(
  parameter int MaxVarintBytes = mfep_pkg::MaxVarintBytes,
  parameter int TimeBits       = mfep_pkg::TimeBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // end_of_file
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_kind[1:0], track_number[17:2], event_time[49:18], status_value[57:50],
  // arg_one[65:58], arg_two[73:66], arg_three[81:74], track_channel[86:82],
  // error_code[91:87], ticks_per_quarter[106:92], zero fill above
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast    // run_last
);

  logic [1:0]     n;
  mfep_pkg::res_t r0, r1, w;
  logic           space;

  assign s_axis_tready = space;

  mfep_core #(.MaxVarintBytes(MaxVarintBytes), .TimeBits(TimeBits)) u_core (
    .clk_i, .rst_ni, .step_i(s_axis_tvalid && space), .byte_i(s_axis_tdata),
    .eof_i(s_axis_tlast), .n_o(n), .r0_o(r0), .r1_o(r1)
  );

  mfep_outq u_outq (
    .clk_i, .rst_ni, .n_i(n), .r0_i(r0), .r1_i(r1), .space_o(space),
    .valid_o(m_axis_tvalid), .word_o(w), .take_i(m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, w.tpq, w.err, w.chan, w.a3, w.a2, w.a1, w.st,
                         w.tim, w.trk, w.kind};
  assign m_axis_tlast = w.last;

endmodule

// File: rtl/mfep_checker.sv
// Port-level checks on the parser.
module mfep_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // Events never carry a channel or error code.
  a_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tdata[91:82] == 10'd0)
    else $error("event word with channel or error field set");

  // Error and file-done words end their byte's run.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tlast)
    else $error("final word without last flag");

  // An empty result queue always has room for another byte.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no output pending");

  // Nothing comes out of reset.
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

bind midi_file_event_parser mfep_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast
);
